### src/pttf_pkg.sv
// Package for the pan-tilt servo packet framer: item and command types,
// servo bus constants and configuration register indexes.
// No dependencies; every other file in src uses it by scoped names.
package pttf_pkg;

  localparam int RAW_MIN = 0;
  localparam int RAW_MAX = 4095;

  localparam logic [7:0] YAW_SERVO_ID   = 8'd1;
  localparam logic [7:0] PITCH_SERVO_ID = 8'd2;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] WRITE_OP    = 8'h03;
  localparam logic [7:0] TORQUE_ADDR = 8'h28;
  localparam logic [7:0] GOAL_ADDR   = 8'h2A;

  localparam logic [7:0] TORQUE_LEN = 8'd4;
  localparam logic [7:0] GOAL_LEN   = 8'd9;

  localparam logic [3:0] TORQUE_PKT_BYTES = 4'd8;
  localparam logic [3:0] GOAL_PKT_BYTES   = 4'd13;

  localparam logic ACT_ENABLE = 1'b0;
  localparam logic ACT_LOOK   = 1'b1;

  typedef enum logic [2:0] {
    CFG_YAW_MIN        = 3'd0,
    CFG_YAW_MAX        = 3'd1,
    CFG_PITCH_MIN      = 3'd2,
    CFG_PITCH_MAX      = 3'd3,
    CFG_YAW_ZERO_RAW   = 3'd4,
    CFG_PITCH_ZERO_RAW = 3'd5,
    CFG_RAW_PER_DEGREE = 3'd6
  } cfg_reg_t;

  localparam logic signed [12:0] YAW_MIN_RST   = -13'sd1440;
  localparam logic signed [12:0] YAW_MAX_RST   = 13'sd1440;
  localparam logic signed [12:0] PITCH_MIN_RST = -13'sd480;
  localparam logic signed [12:0] PITCH_MAX_RST = 13'sd960;
  localparam logic [11:0] ZERO_RAW_RST         = 12'd2048;
  localparam logic [15:0] RAW_PER_DEGREE_RST   = 16'd2913;

  // Input item as it arrives, the first tdata field in the lowest bits.
  typedef struct packed {
    logic               action;
    logic [15:0]        move_time;
    logic signed [12:0] pitch_angle;
    logic signed [12:0] yaw_angle;
    logic               torque_on;
  } in_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic               look;
    logic               torque_on;
    logic [15:0]        pos_yaw;
    logic [15:0]        pos_pitch;
    logic [15:0]        move_time;
    logic signed [12:0] cur_yaw;
    logic signed [12:0] cur_pitch;
  } cmd_t;

  // Result item fields carried in tdata, the first field in the lowest bits.
  typedef struct packed {
    logic signed [12:0] current_pitch;
    logic signed [12:0] current_yaw;
    logic [7:0]         out_byte;
  } out_item_t;

endpackage

### src/pttf_front.sv
// Front end of the framer: configuration registers, ready flag, angle clamp
// and the raw position conversion pipeline feeding the command queue.
// Depends on pttf_pkg.
module pttf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  pttf_pkg::in_item_t in_item,
  output logic             push,
  output pttf_pkg::cmd_t   push_cmd,
  input  logic             q_full
);

  logic signed [12:0] yaw_min, yaw_max, pitch_min, pitch_max;
  logic [11:0]        yaw_zero_raw, pitch_zero_raw;
  logic [15:0]        raw_per_degree;

  logic               ready_flag;
  logic signed [12:0] stored_yaw, stored_pitch;

  logic               accept, is_look, keep, advance;
  logic signed [12:0] yaw_lo, yaw_c, pitch_lo, pitch_c;

  logic               s1_valid, s1_look, s1_torque;
  logic [15:0]        s1_time;
  logic signed [12:0] s1_yaw, s1_pitch;

  logic               s2_valid, s2_look, s2_torque;
  logic [15:0]        s2_time;
  logic signed [12:0] s2_yaw, s2_pitch;
  logic signed [29:0] s2_prod_yaw, s2_prod_pitch;

  function automatic logic [15:0] to_raw(logic signed [29:0] p, logic [11:0] zero);
    logic signed [29:0] r;
    logic signed [17:0] q;
    logic signed [18:0] s;
    logic [15:0]        res;
    r = p + (p[29] ? 30'sd2047 : 30'sd2048);
    q = r[29:12];
    s = $signed({7'b0, zero}) + $signed({q[17], q});
    if (s < $signed(19'(pttf_pkg::RAW_MIN))) begin
      res = 16'(pttf_pkg::RAW_MIN);
    end else if (s > $signed(19'(pttf_pkg::RAW_MAX))) begin
      res = 16'(pttf_pkg::RAW_MAX);
    end else begin
      res = s[15:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_min        <= pttf_pkg::YAW_MIN_RST;
      yaw_max        <= pttf_pkg::YAW_MAX_RST;
      pitch_min      <= pttf_pkg::PITCH_MIN_RST;
      pitch_max      <= pttf_pkg::PITCH_MAX_RST;
      yaw_zero_raw   <= pttf_pkg::ZERO_RAW_RST;
      pitch_zero_raw <= pttf_pkg::ZERO_RAW_RST;
      raw_per_degree <= pttf_pkg::RAW_PER_DEGREE_RST;
    end else if (cfg_we) begin
      case (pttf_pkg::cfg_reg_t'(cfg_index))
        pttf_pkg::CFG_YAW_MIN:        yaw_min        <= cfg_data[12:0];
        pttf_pkg::CFG_YAW_MAX:        yaw_max        <= cfg_data[12:0];
        pttf_pkg::CFG_PITCH_MIN:      pitch_min      <= cfg_data[12:0];
        pttf_pkg::CFG_PITCH_MAX:      pitch_max      <= cfg_data[12:0];
        pttf_pkg::CFG_YAW_ZERO_RAW:   yaw_zero_raw   <= cfg_data[11:0];
        pttf_pkg::CFG_PITCH_ZERO_RAW: pitch_zero_raw <= cfg_data[11:0];
        pttf_pkg::CFG_RAW_PER_DEGREE: raw_per_degree <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !s2_valid || !q_full;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;
  assign is_look  = (in_item.action == pttf_pkg::ACT_LOOK);
  assign keep     = accept && (!is_look || ready_flag);

  // A value below the lower limit ends there, even when the limits cross.
  always_comb begin
    yaw_lo   = (in_item.yaw_angle > yaw_max) ? yaw_max : in_item.yaw_angle;
    yaw_c    = (in_item.yaw_angle < yaw_min) ? yaw_min : yaw_lo;
    pitch_lo = (in_item.pitch_angle > pitch_max) ? pitch_max : in_item.pitch_angle;
    pitch_c  = (in_item.pitch_angle < pitch_min) ? pitch_min : pitch_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag   <= 1'b0;
      stored_yaw   <= '0;
      stored_pitch <= '0;
    end else if (accept) begin
      if (!is_look) begin
        ready_flag <= 1'b1;
      end else if (ready_flag) begin
        stored_yaw   <= yaw_c;
        stored_pitch <= pitch_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= keep;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_look   <= is_look;
      s1_torque <= in_item.torque_on;
      s1_time   <= in_item.move_time;
      s1_yaw    <= is_look ? yaw_c : stored_yaw;
      s1_pitch  <= is_look ? pitch_c : stored_pitch;

      s2_look       <= s1_look;
      s2_torque     <= s1_torque;
      s2_time       <= s1_time;
      s2_yaw        <= s1_yaw;
      s2_pitch      <= s1_pitch;
      s2_prod_yaw   <= s1_yaw * $signed({1'b0, raw_per_degree});
      s2_prod_pitch <= s1_pitch * $signed({1'b0, raw_per_degree});
    end
  end

  assign push = s2_valid && !q_full;

  always_comb begin
    push_cmd.look      = s2_look;
    push_cmd.torque_on = s2_torque;
    push_cmd.pos_yaw   = to_raw(s2_prod_yaw, yaw_zero_raw);
    push_cmd.pos_pitch = to_raw(s2_prod_pitch, pitch_zero_raw);
    push_cmd.move_time = s2_time;
    push_cmd.cur_yaw   = s2_yaw;
    push_cmd.cur_pitch = s2_pitch;
  end

endmodule

### src/pttf_queue.sv
// Two-entry command queue between the front end and the packet serializer.
// Depends on pttf_pkg for the command type.
module pttf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pttf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output pttf_pkg::cmd_t pop_cmd,
  output logic           not_empty
);

  pttf_pkg::cmd_t mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### src/pttf_back.sv
// Packet serializer: turns one queued command into two servo write packets,
// one byte per transfer, through a registered output stage.
// Depends on pttf_pkg.
module pttf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  pttf_pkg::cmd_t    q_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pttf_pkg::out_item_t out_item,
  output logic              out_last
);

  localparam logic [3:0] IDX_SYNC0 = 4'd0;
  localparam logic [3:0] IDX_SYNC1 = 4'd1;
  localparam logic [3:0] IDX_ID    = 4'd2;
  localparam logic [3:0] IDX_LEN   = 4'd3;
  localparam logic [3:0] IDX_OP    = 4'd4;
  localparam logic [3:0] IDX_ADDR  = 4'd5;
  localparam logic [3:0] IDX_D0    = 4'd6;
  localparam logic [3:0] IDX_D1    = 4'd7;
  localparam logic [3:0] IDX_D2    = 4'd8;
  localparam logic [3:0] IDX_D3    = 4'd9;

  pttf_pkg::cmd_t cur;
  logic           busy, pkt;
  logic [3:0]     idx, pkt_bytes;
  logic           last_in_pkt, last_byte, adv, emit;
  logic [7:0]     id, len, addr, pos_hi, pos_lo, sum, byte_val;
  logic [15:0]    pos;

  always_comb begin
    pkt_bytes   = cur.look ? pttf_pkg::GOAL_PKT_BYTES : pttf_pkg::TORQUE_PKT_BYTES;
    last_in_pkt = (idx == pkt_bytes - 4'd1);
    last_byte   = pkt && last_in_pkt;
    id     = pkt ? pttf_pkg::PITCH_SERVO_ID : pttf_pkg::YAW_SERVO_ID;
    len    = cur.look ? pttf_pkg::GOAL_LEN : pttf_pkg::TORQUE_LEN;
    addr   = cur.look ? pttf_pkg::GOAL_ADDR : pttf_pkg::TORQUE_ADDR;
    pos    = pkt ? cur.pos_pitch : cur.pos_yaw;
    pos_hi = pos[15:8];
    pos_lo = pos[7:0];
    sum    = id + len + pttf_pkg::WRITE_OP + addr;
    if (cur.look) begin
      sum = sum + pos_hi + pos_lo + cur.move_time[15:8] + cur.move_time[7:0];
    end else begin
      sum = sum + {7'b0, cur.torque_on};
    end

    if (last_in_pkt) begin
      byte_val = ~sum;
    end else begin
      case (idx)
        IDX_SYNC0, IDX_SYNC1: byte_val = pttf_pkg::SYNC_BYTE;
        IDX_ID:   byte_val = id;
        IDX_LEN:  byte_val = len;
        IDX_OP:   byte_val = pttf_pkg::WRITE_OP;
        IDX_ADDR: byte_val = addr;
        IDX_D0:   byte_val = cur.look ? pos_hi : {7'b0, cur.torque_on};
        IDX_D1:   byte_val = pos_lo;
        IDX_D2:   byte_val = cur.move_time[15:8];
        IDX_D3:   byte_val = cur.move_time[7:0];
        default:  byte_val = 8'h00;
      endcase
    end
  end

  assign adv  = !out_valid || out_ready;
  assign emit = busy && adv;
  assign pop  = q_valid && (!busy || (emit && last_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pkt       <= 1'b0;
      idx       <= '0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        pkt  <= 1'b0;
        idx  <= '0;
      end else if (emit) begin
        if (last_byte) begin
          busy <= 1'b0;
        end else if (last_in_pkt) begin
          pkt <= 1'b1;
          idx <= '0;
        end else begin
          idx <= idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_cmd;
    end
    if (emit) begin
      out_item.out_byte      <= byte_val;
      out_item.current_yaw   <= cur.cur_yaw;
      out_item.current_pitch <= cur.cur_pitch;
      out_last               <= last_byte;
    end
  end

endmodule

### src/pan_tilt_servo_packet_framer_core.sv
// Top level of the pan-tilt servo packet framer: stream ports, front end,
// command queue and packet serializer. Depends on pttf_pkg, pttf_front,
// pttf_queue and pttf_back.
//
//  Channel  Direction  Handshake          Contents
//  s_*      in         s_tvalid/s_tready  command: tuser action, tdata fields
//  m_*      out        m_tvalid/m_tready  packet byte with stored angles, tlast
//  cfg_*    in         cfg_we             register index and write data
//
// An enable command gives 16 output bytes and a look command 26, one byte per
// cycle from the serializer while the output does not stall; a look command
// dropped while not ready gives none. A command passes stages s1 and s2 before
// it enters the queue, and its bytes leave through the registered byte stage.
// The queue holds two commands, so input keeps flowing while the serializer works.
// Reset is synchronous and restores registers, ready flag and stored angles.
// Output stalls hold the byte stage, then the queue, then the input.
module pan_tilt_servo_packet_framer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // torque_on, yaw_angle, pitch_angle, move_time
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte, current_yaw, current_pitch
  output logic        m_tlast,   // end_of_run
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  pttf_pkg::in_item_t  in_item;
  pttf_pkg::cmd_t      push_cmd, pop_cmd;
  pttf_pkg::out_item_t out_item;
  logic                push, q_full, pop, q_valid;

  assign in_item = {s_tuser, s_tdata[42:0]};
  assign m_tdata = {6'b0, out_item};

  pttf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  pttf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .not_empty(q_valid)
  );

  pttf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_item (out_item),
    .out_last (m_tlast)
  );

endmodule

### src/pttf_checker.sv
// Port-level checker for the pan-tilt servo packet framer, bound to the top.
// Depends on pttf_pkg and pan_tilt_servo_packet_framer_core.
module pttf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  logic [4:0] run_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
    end else if (m_tvalid && m_tready) begin
      run_count <= m_tlast ? 5'd0 : run_count + 5'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled output transfer changed.");

  a_sync: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (run_count == 5'd0 || run_count == 5'd1)
      |-> m_tdata[7:0] == pttf_pkg::SYNC_BYTE)
    else $error("Run does not open with two sync bytes.");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> run_count == 5'd15 || run_count == 5'd25)
    else $error("Run ends after a wrong number of bytes.");

endmodule

bind pan_tilt_servo_packet_framer_core pttf_checker u_pttf_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

### tb/sv/tb_pttf_checker.sv
`timescale 1ns / 1ps
// Checker for the pan-tilt servo packet framer: watches the command, packet and
// register write channels, predicts every packet byte and compares in order.
// Depends on pttf_pkg for item layout and servo bus constants.
module tb_pttf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [7:0]         data;
    logic               last;
    logic signed [12:0] yaw;
    logic signed [12:0] pitch;
  } bus_byte_t;

  bus_byte_t          bytes_due[$];
  logic [7:0]         run_bytes[$];
  int                 fail_count = 0;

  logic signed [12:0] yaw_lo, yaw_hi, pitch_lo, pitch_hi;
  logic [11:0]        yaw_zero, pitch_zero;
  logic [15:0]        gain;
  logic               servos_ready;
  logic signed [12:0] held_yaw, held_pitch;

  assign errors = fail_count;

  function automatic logic signed [12:0] limit_angle(input logic signed [12:0] a,
                                                     input logic signed [12:0] lo,
                                                     input logic signed [12:0] hi);
    if (a < lo) return lo;
    if (a > hi) return hi;
    return a;
  endfunction

  function automatic logic [15:0] goal_position(input logic [11:0] zero,
                                                input logic signed [12:0] angle);
    longint prod, mag, steps, raw;
    prod = longint'(angle) * longint'(gain);
    mag = (prod < 0) ? -prod : prod;
    steps = (mag + 2048) / 4096;
    if (prod < 0) steps = -steps;
    raw = longint'(zero) + steps;
    if (raw < pttf_pkg::RAW_MIN) raw = pttf_pkg::RAW_MIN;
    if (raw > pttf_pkg::RAW_MAX) raw = pttf_pkg::RAW_MAX;
    return raw[15:0];
  endfunction

  // Payload bytes go out from the top of the vector down.
  function automatic void add_packet(input logic [7:0] id, input logic [7:0] addr,
                                     input int n, input logic [47:0] payload);
    logic [7:0] len, sum, b;
    len = 8'(n + 3);
    sum = id + len + pttf_pkg::WRITE_OP + addr;
    run_bytes.push_back(pttf_pkg::SYNC_BYTE);
    run_bytes.push_back(pttf_pkg::SYNC_BYTE);
    run_bytes.push_back(id);
    run_bytes.push_back(len);
    run_bytes.push_back(pttf_pkg::WRITE_OP);
    run_bytes.push_back(addr);
    for (int k = 0; k < n; k++) begin
      b = payload[8 * (n - 1 - k) +: 8];
      run_bytes.push_back(b);
      sum = sum + b;
    end
    run_bytes.push_back(~sum);
  endfunction

  function automatic void frame_command(input logic action, input logic torque,
                                        input logic signed [12:0] yaw,
                                        input logic signed [12:0] pitch,
                                        input logic [15:0] move_time);
    bus_byte_t e;
    run_bytes.delete();
    if (action == pttf_pkg::ACT_ENABLE) begin
      servos_ready = 1'b1;
      add_packet(pttf_pkg::YAW_SERVO_ID, pttf_pkg::TORQUE_ADDR, 1, {47'd0, torque});
      add_packet(pttf_pkg::PITCH_SERVO_ID, pttf_pkg::TORQUE_ADDR, 1, {47'd0, torque});
    end else begin
      if (!servos_ready) return;
      held_yaw = limit_angle(yaw, yaw_lo, yaw_hi);
      held_pitch = limit_angle(pitch, pitch_lo, pitch_hi);
      add_packet(pttf_pkg::YAW_SERVO_ID, pttf_pkg::GOAL_ADDR, 6,
                 {goal_position(yaw_zero, held_yaw), move_time, 16'd0});
      add_packet(pttf_pkg::PITCH_SERVO_ID, pttf_pkg::GOAL_ADDR, 6,
                 {goal_position(pitch_zero, held_pitch), move_time, 16'd0});
    end
    foreach (run_bytes[k]) begin
      e.data = run_bytes[k];
      e.last = (k == run_bytes.size() - 1);
      e.yaw = held_yaw;
      e.pitch = held_pitch;
      bytes_due.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    pttf_pkg::out_item_t got;
    bus_byte_t want;
    if (rst) begin
      yaw_lo = pttf_pkg::YAW_MIN_RST;
      yaw_hi = pttf_pkg::YAW_MAX_RST;
      pitch_lo = pttf_pkg::PITCH_MIN_RST;
      pitch_hi = pttf_pkg::PITCH_MAX_RST;
      yaw_zero = pttf_pkg::ZERO_RAW_RST;
      pitch_zero = pttf_pkg::ZERO_RAW_RST;
      gain = pttf_pkg::RAW_PER_DEGREE_RST;
      servos_ready = 1'b0;
      held_yaw = '0;
      held_pitch = '0;
      bytes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pttf_pkg::CFG_YAW_MIN:        yaw_lo = cfg_data[12:0];
          pttf_pkg::CFG_YAW_MAX:        yaw_hi = cfg_data[12:0];
          pttf_pkg::CFG_PITCH_MIN:      pitch_lo = cfg_data[12:0];
          pttf_pkg::CFG_PITCH_MAX:      pitch_hi = cfg_data[12:0];
          pttf_pkg::CFG_YAW_ZERO_RAW:   yaw_zero = cfg_data[11:0];
          pttf_pkg::CFG_PITCH_ZERO_RAW: pitch_zero = cfg_data[11:0];
          pttf_pkg::CFG_RAW_PER_DEGREE: gain = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        frame_command(s_tuser[0], s_tdata[0], s_tdata[13:1], s_tdata[26:14],
                      s_tdata[42:27]);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(pttf_pkg::out_item_t)-1:0];
        if (bytes_due.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected byte %h last %b yaw %0d pitch %0d", $realtime,
                     got.out_byte, m_tlast, got.current_yaw, got.current_pitch);
          end
          fail_count++;
        end else begin
          want = bytes_due.pop_front();
          if (got.out_byte !== want.data || m_tlast !== want.last ||
              got.current_yaw !== want.yaw || got.current_pitch !== want.pitch) begin
            if (fail_count < 10) begin
              $display("%0t: expected byte %h last %b yaw %0d pitch %0d", $realtime,
                       want.data, want.last, want.yaw, want.pitch);
              $display("%0t:      got byte %h last %b yaw %0d pitch %0d", $realtime,
                       got.out_byte, m_tlast, got.current_yaw, got.current_pitch);
            end
            fail_count++;
          end
        end
      end
    end
    pending = bytes_due.size();
  end

endmodule

### tb/sv/tb_pan_tilt_servo_packet_framer_core.sv
`timescale 1ns / 1ps
// Top of the pan-tilt servo packet framer testbench: clock, reset, register
// writes, command stimulus and the verdict. Depends on pttf_pkg, the core and
// tb_pttf_checker.
module tb_pan_tilt_servo_packet_framer_core;

  localparam logic [2:0] CFG_SPARE = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int check_errors;
  int bytes_pending;
  int src_gap_pct = 10;
  int sink_stall_pct = 10;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pan_tilt_servo_packet_framer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tb_pttf_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (check_errors),
    .pending   (bytes_pending)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [12:0] rand_angle();
    if ($urandom_range(3) == 0) return 13'($urandom);
    return 13'(int'($urandom_range(5760)) - 2880);
  endfunction

  task automatic send_cmd(input logic action, input logic torque,
                          input logic signed [12:0] yaw, input logic signed [12:0] pitch,
                          input logic [15:0] move_time);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= action;
    s_tdata <= {5'd0, move_time, pitch, yaw, torque};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Dropped look commands leave nothing to wait for, so a fixed pause follows.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic apply_limits(input logic signed [12:0] ymin, input logic signed [12:0] ymax,
                              input logic signed [12:0] pmin, input logic signed [12:0] pmax,
                              input logic [11:0] yzero, input logic [11:0] pzero,
                              input logic [15:0] gain);
    logic [15:0] vals[8];
    vals[pttf_pkg::CFG_YAW_MIN] = {{3{ymin[12]}}, ymin};
    vals[pttf_pkg::CFG_YAW_MAX] = {{3{ymax[12]}}, ymax};
    vals[pttf_pkg::CFG_PITCH_MIN] = {{3{pmin[12]}}, pmin};
    vals[pttf_pkg::CFG_PITCH_MAX] = {{3{pmax[12]}}, pmax};
    vals[pttf_pkg::CFG_YAW_ZERO_RAW] = {4'd0, yzero};
    vals[pttf_pkg::CFG_PITCH_ZERO_RAW] = {4'd0, pzero};
    vals[pttf_pkg::CFG_RAW_PER_DEGREE] = gain;
    vals[CFG_SPARE] = 16'($urandom);
    for (int i = pttf_pkg::CFG_YAW_MIN; i <= CFG_SPARE; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic signed [12:0] a, b, c, d;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(pttf_pkg::ACT_LOOK, 1'b1, 13'sd100, 13'sd50, 16'd1234);
    wait_drained();
    send_cmd(pttf_pkg::ACT_ENABLE, 1'b1, 13'sd0, 13'sd0, 16'd0);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd0, 13'sd0, 16'd0);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b1, 13'sd4095, -13'sd4096, 16'hFFFF);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, -13'sd4096, 13'sd4095, 16'h8001);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd1440, 13'sd960, 16'h00FF);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, -13'sd1440, -13'sd480, 16'hFF00);
    send_cmd(pttf_pkg::ACT_ENABLE, 1'b0, -13'sd1, -13'sd1, 16'hFFFF);
    wait_drained();

    apply_limits(-13'sd4096, 13'sd4095, -13'sd4096, 13'sd4095, 12'd2048, 12'd2048, 16'd256);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd8, -13'sd8, 16'd10);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd24, -13'sd24, 16'd20);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd4095, -13'sd4096, 16'd30);
    wait_drained();

    apply_limits(-13'sd4096, 13'sd4095, -13'sd4096, 13'sd4095, 12'd4095, 12'd0, 16'hFFFF);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd4095, -13'sd4096, 16'd500);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, -13'sd1, 13'sd1, 16'd500);
    wait_drained();

    apply_limits(13'sd100, -13'sd100, 13'sd2880, -13'sd2880, 12'd0, 12'd4095, 16'd0);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, -13'sd500, 13'sd3000, 16'd1);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd0, 13'sd0, 16'd2);
    send_cmd(pttf_pkg::ACT_LOOK, 1'b0, 13'sd500, -13'sd3000, 16'd3);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      src_gap_pct = (phase == 0) ? 0 : 10;
      sink_stall_pct = (phase == 0) ? 0 : 10;
      if (phase == 1) begin
        apply_limits(pttf_pkg::YAW_MIN_RST, pttf_pkg::YAW_MAX_RST,
                     pttf_pkg::PITCH_MIN_RST, pttf_pkg::PITCH_MAX_RST,
                     pttf_pkg::ZERO_RAW_RST, pttf_pkg::ZERO_RAW_RST,
                     pttf_pkg::RAW_PER_DEGREE_RST);
      end else begin
        a = rand_angle();
        b = rand_angle();
        c = rand_angle();
        d = rand_angle();
        if (phase != 4) begin
          if (a > b) {a, b} = {b, a};
          if (c > d) {c, d} = {d, c};
        end
        apply_limits(a, b, c, d, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                     ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(8191)));
      end
      for (int n = 0; n < 90; n++) begin
        send_cmd(($urandom_range(99) < 12) ? pttf_pkg::ACT_ENABLE : pttf_pkg::ACT_LOOK,
                 1'($urandom), rand_angle(), rand_angle(), 16'($urandom));
      end
      wait_drained();
    end

    repeat (30) @(negedge clk);
    if (check_errors == 0 && bytes_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
